// ===== hw/rtl/ppee_pkg.sv =====
// ----------------------------------------------------------------------------
// ppee_pkg
// Shared types, constants and command codes for the pulse power estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package ppee_pkg;

	localparam int PPEE_PULSE_COUNT_BITS = 16;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_METER_RATE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WATTS_LOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WATTS_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_MIN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_MAX  = 3'd4;
	localparam int CFG_DATA_W = 24;

	localparam logic [15:0] RST_METER_RATE = 16'd1000;
	localparam logic [23:0] RST_WATTS_LOW  = 24'd100;
	localparam logic [23:0] RST_WATTS_HIGH = 24'd3000;
	localparam logic [16:0] RST_ALPHA_MIN  = 17'd6554;
	localparam logic [16:0] RST_ALPHA_MAX  = 17'd32768;

	localparam logic [31:0] MIN_GAP_MS    = 32'd1000;
	localparam logic [31:0] MS_WH_PER_KWH = 32'd3600000000;
	localparam logic [16:0] ALPHA_ONE     = 17'd65536;

	// request types
	localparam logic REQ_PULSE = 1'b0;
	localparam logic REQ_TIME  = 1'b1;

	// datapath commands
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
	localparam logic [OP_W-1:0] OP_ACCEPT     = 4'd1;
	localparam logic [OP_W-1:0] OP_MUL_NUM    = 4'd2;
	localparam logic [OP_W-1:0] OP_MUL_DEN    = 4'd3;
	localparam logic [OP_W-1:0] OP_DIVI_INIT  = 4'd4;
	localparam logic [OP_W-1:0] OP_DIV_STEP   = 4'd5;
	localparam logic [OP_W-1:0] OP_INST_DONE  = 4'd6;
	localparam logic [OP_W-1:0] OP_ALPHA_PREP = 4'd7;
	localparam logic [OP_W-1:0] OP_ALPHA_MUL  = 4'd8;
	localparam logic [OP_W-1:0] OP_DIVA_INIT  = 4'd9;
	localparam logic [OP_W-1:0] OP_ALPHA_DONE = 4'd10;
	localparam logic [OP_W-1:0] OP_EMA_MUL    = 4'd11;
	localparam logic [OP_W-1:0] OP_EMA_DONE   = 4'd12;

	typedef struct packed {
		logic        req_type;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [31:0] power_q8;
		logic [16:0] alpha_q16;
		logic [15:0] window_ms;
		logic        window_closed;
	} out_item_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
	} ppee_cmd_t;

	typedef struct packed {
		logic close_req;  // presented item will close a window
		logic out_free;   // output register can take an item this cycle
	} ppee_status_t;

	// next window length from the pulse count of the closing window
	function automatic logic [15:0] next_window(input logic [31:0] n);
		logic [15:0] w;
		if (n == 32'd0)       w = 16'd40000;
		else if (n <= 32'd2)  w = 16'd25000;
		else if (n <= 32'd6)  w = 16'd15000;
		else if (n <= 32'd12) w = 16'd8000;
		else                  w = 16'd5000;
		return w;
	endfunction

	function automatic logic [16:0] clamp_alpha(input logic [16:0] a);
		return (a > ALPHA_ONE) ? ALPHA_ONE : a;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pulse_power_ema_estimator_top.sv =====
// ----------------------------------------------------------------------------
// pulse_power_ema_estimator_top
// Pulse-counting power estimator with adaptive exponential smoothing.
// ----------------------------------------------------------------------------
// Pulse items and time items that do not close a window: result in the next cycle.
// A window close runs after accept as two 32-step restoring divisions
// (instant power, alpha interpolation) on one shared divider plus multiply steps.
// One item in flight at a time; a new item is taken once the output register is free.
// Reset: asynchronous, clears window state, power and alpha; config to defaults.
`default_nettype none

module pulse_power_ema_estimator_top
	import ppee_pkg::*;
#(
	parameter int PULSE_COUNT_BITS = PPEE_PULSE_COUNT_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output      logic                  in_stall,
	input  wire in_item_t              in_data,
	output      logic                  out_valid,
	input  wire logic                  out_stall,
	output      out_item_t             out_data
);

	ppee_cmd_t    cmd;
	ppee_status_t status;

	ppee_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	ppee_dp #(
		.PULSE_COUNT_BITS (PULSE_COUNT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/ppee_ctrl.sv =====
// ----------------------------------------------------------------------------
// ppee_ctrl
// Sequencer: accepts items and steps the datapath through a window close.
// ----------------------------------------------------------------------------
`default_nettype none

module ppee_ctrl
	import ppee_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output      logic         in_stall,
	input  wire ppee_status_t status,
	output      ppee_cmd_t    cmd
);

	localparam logic [3:0] S_IDLE       = 4'd0;
	localparam logic [3:0] S_MUL_NUM    = 4'd1;
	localparam logic [3:0] S_MUL_DEN    = 4'd2;
	localparam logic [3:0] S_DIVI_INIT  = 4'd3;
	localparam logic [3:0] S_DIV_I      = 4'd4;
	localparam logic [3:0] S_INST_DONE  = 4'd5;
	localparam logic [3:0] S_ALPHA_PREP = 4'd6;
	localparam logic [3:0] S_ALPHA_MUL  = 4'd7;
	localparam logic [3:0] S_DIVA_INIT  = 4'd8;
	localparam logic [3:0] S_DIV_A      = 4'd9;
	localparam logic [3:0] S_ALPHA_DONE = 4'd10;
	localparam logic [3:0] S_EMA_MUL    = 4'd11;
	localparam logic [3:0] S_EMA_DONE   = 4'd12;

	logic [3:0] state_q, state_d;
	logic [4:0] step_q;
	logic       accept;

	assign in_stall = !((state_q == S_IDLE) && status.out_free);
	assign accept   = in_valid && !in_stall;

	// next state and command
	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.op = OP_ACCEPT;
					if (status.close_req) state_d = S_MUL_NUM;
				end
			end
			S_MUL_NUM: begin
				cmd.op  = OP_MUL_NUM;
				state_d = S_MUL_DEN;
			end
			S_MUL_DEN: begin
				cmd.op  = OP_MUL_DEN;
				state_d = S_DIVI_INIT;
			end
			S_DIVI_INIT: begin
				cmd.op  = OP_DIVI_INIT;
				state_d = S_DIV_I;
			end
			S_DIV_I: begin
				cmd.op = OP_DIV_STEP;
				if (step_q == 5'd31) state_d = S_INST_DONE;
			end
			S_INST_DONE: begin
				cmd.op  = OP_INST_DONE;
				state_d = S_ALPHA_PREP;
			end
			S_ALPHA_PREP: begin
				cmd.op  = OP_ALPHA_PREP;
				state_d = S_ALPHA_MUL;
			end
			S_ALPHA_MUL: begin
				cmd.op  = OP_ALPHA_MUL;
				state_d = S_DIVA_INIT;
			end
			S_DIVA_INIT: begin
				cmd.op  = OP_DIVA_INIT;
				state_d = S_DIV_A;
			end
			S_DIV_A: begin
				cmd.op = OP_DIV_STEP;
				if (step_q == 5'd31) state_d = S_ALPHA_DONE;
			end
			S_ALPHA_DONE: begin
				cmd.op  = OP_ALPHA_DONE;
				state_d = S_EMA_MUL;
			end
			S_EMA_MUL: begin
				cmd.op  = OP_EMA_MUL;
				state_d = S_EMA_DONE;
			end
			S_EMA_DONE: begin
				// hold until the output register is free
				if (status.out_free) begin
					cmd.op  = OP_EMA_DONE;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and division step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= 5'd0;
		end else begin
			state_q <= state_d;
			if (state_q inside {S_DIV_I, S_DIV_A}) step_q <= step_q + 5'd1;
			else                                   step_q <= 5'd0;
		end
	end

	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (step_q == 5'd0))
		else $error("step counter not clear in idle");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INST_DONE) |-> ($past(step_q) == 5'd31))
		else $error("division did not run 32 steps");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_ACCEPT) |=> (state_q == S_IDLE || state_q == S_MUL_NUM))
		else $error("accept left the sequencer in a bad state");

endmodule

`default_nettype wire

// ===== hw/rtl/ppee_dp.sv =====
// ----------------------------------------------------------------------------
// ppee_dp
// Datapath: config and window state, shared multiplier, restoring divider,
// alpha interpolation, EMA update and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ppee_dp
	import ppee_pkg::*;
#(
	parameter int PULSE_COUNT_BITS = PPEE_PULSE_COUNT_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire in_item_t              in_data,
	input  wire ppee_cmd_t             cmd,
	output      ppee_status_t          status,
	output      logic                  out_valid,
	input  wire logic                  out_stall,
	output      out_item_t             out_data
);

	// configuration
	logic [15:0] ppk_q;
	logic [23:0] wlow_q, whigh_q;
	logic [16:0] amin_q, amax_q;

	// window state
	logic [PULSE_COUNT_BITS-1:0] cnt_q;
	logic [31:0] start_q, last_q, power_q;
	logic [15:0] dur_q;
	logic [16:0] alpha_q;

	// work registers
	logic [31:0] now_q, elapsed_q, inst_q, off_q, span_q, pdiff_q;
	logic [63:0] num_q;
	logic [47:0] den_q, rem_q, dvs_q;
	logic [31:0] dvd_q;
	logic [16:0] adiff_q;
	logic        sat_q, le_q, ge_q, aup_q, pup_q;

	out_item_t out_q;
	logic      out_valid_q;

	// item decode
	logic [31:0] gap, elapsed;
	logic        acting, closing;
	assign gap     = in_data.now_ms - last_q;
	assign elapsed = in_data.now_ms - start_q;
	assign acting  = (in_data.req_type == REQ_TIME) && (gap >= MIN_GAP_MS);
	assign closing = acting && (elapsed >= {16'd0, dur_q});

	assign status.close_req = closing;
	assign status.out_free  = !out_valid_q || !out_stall;

	// shared 32x32 multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	always_comb begin
		mul_a = 32'd0;
		mul_b = 32'd0;
		case (cmd.op)
			OP_MUL_NUM: begin
				mul_a = 32'(cnt_q);
				mul_b = MS_WH_PER_KWH;
			end
			OP_MUL_DEN: begin
				mul_a = elapsed_q;
				mul_b = {16'd0, ppk_q};
			end
			OP_ALPHA_MUL: begin
				mul_a = off_q;
				mul_b = {15'd0, adiff_q};
			end
			OP_EMA_MUL: begin
				mul_a = pdiff_q;
				mul_b = {15'd0, alpha_q};
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// one restoring division step
	logic [48:0] trial;
	logic        trial_ge;
	assign trial    = {rem_q, dvd_q[31]};
	assign trial_ge = trial >= {1'b0, dvs_q};

	// alpha thresholds and clamped alpha limits
	logic [31:0] lo32, hi32;
	logic [16:0] amin_c, amax_c;
	assign lo32   = {wlow_q, 8'd0};
	assign hi32   = {whigh_q, 8'd0};
	assign amin_c = clamp_alpha(amin_q);
	assign amax_c = clamp_alpha(amax_q);

	// alpha selection
	logic [16:0] alpha_new;
	always_comb begin
		if (le_q)       alpha_new = amin_c;
		else if (ge_q)  alpha_new = amax_c;
		else if (aup_q) alpha_new = amin_c + dvd_q[16:0];
		else            alpha_new = amin_c - dvd_q[16:0];
	end

	// EMA result and next window
	logic [31:0] ema_step, power_new;
	logic [15:0] dur_new;
	assign ema_step  = num_q[47:16];
	assign power_new = pup_q ? (power_q + ema_step) : (power_q - ema_step);
	assign dur_new   = next_window(32'(cnt_q));

	// config, window state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppk_q       <= RST_METER_RATE;
			wlow_q      <= RST_WATTS_LOW;
			whigh_q     <= RST_WATTS_HIGH;
			amin_q      <= RST_ALPHA_MIN;
			amax_q      <= RST_ALPHA_MAX;
			cnt_q       <= '0;
			start_q     <= 32'd0;
			last_q      <= 32'd0;
			dur_q       <= 16'd0;
			power_q     <= 32'd0;
			alpha_q     <= 17'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_METER_RATE: ppk_q   <= cfg_data[15:0];
					CFG_WATTS_LOW:  wlow_q  <= cfg_data;
					CFG_WATTS_HIGH: whigh_q <= cfg_data;
					CFG_ALPHA_MIN:  amin_q  <= cfg_data[16:0];
					CFG_ALPHA_MAX:  amax_q  <= cfg_data[16:0];
					default: ;
				endcase
			end
			// output valid: set by a new item, cleared when taken
			if ((cmd.op == OP_EMA_DONE) || ((cmd.op == OP_ACCEPT) && !closing))
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (cmd.op)
				OP_ACCEPT: begin
					if (in_data.req_type == REQ_PULSE) begin
						if (cnt_q != '1) cnt_q <= cnt_q + PULSE_COUNT_BITS'(1);
					end else if (acting) begin
						last_q <= in_data.now_ms;
					end
				end
				OP_ALPHA_DONE: alpha_q <= alpha_new;
				OP_EMA_DONE: begin
					power_q <= power_new;
					dur_q   <= dur_new;
					cnt_q   <= '0;
					start_q <= now_q;
				end
				default: ;
			endcase
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_ACCEPT: begin
				out_q.power_q8      <= power_q;
				out_q.alpha_q16     <= alpha_q;
				out_q.window_ms     <= dur_q;
				out_q.window_closed <= 1'b0;
			end
			OP_EMA_DONE: begin
				out_q.power_q8      <= power_new;
				out_q.alpha_q16     <= alpha_q;
				out_q.window_ms     <= dur_new;
				out_q.window_closed <= 1'b1;
			end
			default: ;
		endcase
	end

	// work registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_ACCEPT: begin
				now_q     <= in_data.now_ms;
				elapsed_q <= elapsed;
			end
			OP_MUL_NUM: num_q <= mul_p;
			OP_MUL_DEN: den_q <= mul_p[47:0];
			OP_DIVI_INIT: begin
				// quotient of (num << 8) / den; saturate when it needs over 32 bits
				rem_q <= 48'(num_q[63:24]);
				dvd_q <= {num_q[23:0], 8'd0};
				dvs_q <= den_q;
				sat_q <= (den_q == 48'd0) || ({8'd0, num_q[63:24]} >= den_q);
			end
			OP_DIV_STEP: begin
				rem_q <= trial_ge ? 48'(trial - {1'b0, dvs_q}) : trial[47:0];
				dvd_q <= {dvd_q[30:0], trial_ge};
			end
			OP_INST_DONE: inst_q <= sat_q ? 32'hFFFF_FFFF : dvd_q;
			OP_ALPHA_PREP: begin
				le_q    <= inst_q <= lo32;
				ge_q    <= inst_q >= hi32;
				off_q   <= inst_q - lo32;
				span_q  <= hi32 - lo32;
				aup_q   <= amax_c >= amin_c;
				adiff_q <= (amax_c >= amin_c) ? (amax_c - amin_c) : (amin_c - amax_c);
			end
			OP_ALPHA_MUL: num_q <= mul_p;
			OP_DIVA_INIT: begin
				rem_q <= {16'd0, num_q[63:32]};
				dvd_q <= num_q[31:0];
				dvs_q <= {16'd0, span_q};
				sat_q <= le_q || ge_q;
			end
			OP_ALPHA_DONE: begin
				pup_q   <= inst_q >= power_q;
				pdiff_q <= (inst_q >= power_q) ? (inst_q - power_q) : (power_q - inst_q);
			end
			OP_EMA_MUL: num_q <= mul_p;
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_alpha_range: assert property (@(posedge clk) disable iff (!arst_n)
		alpha_q <= ALPHA_ONE)
		else $error("alpha above one");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_DIV_STEP) |-> (sat_q || rem_q < dvs_q))
		else $error("divider remainder out of range");

	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_EMA_DONE) |=> (cnt_q == '0 && out_valid_q && out_q.window_closed))
		else $error("window close did not restart window");

endmodule

`default_nettype wire
